// ===== design/dglcd_pkg.sv =====
// Shared types, constants and helper functions for the two-half graphic LCD controller.
// No dependencies; the top and dglcd_half refer to it by scoped names.
`default_nettype none

package dglcd_pkg;

    // Geometry of one half
    localparam int COLUMNS_PER_HALF = 64;
    localparam int PAGE_COUNT       = 8;
    localparam int HALF_DEPTH       = PAGE_COUNT * COLUMNS_PER_HALF;
    localparam int ADDR_W           = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int COL_W            = $clog2(COLUMNS_PER_HALF);
    localparam int PAGE_W           = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    // Bus access codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // Instruction bytes and masks
    localparam logic [7:0] INSTR_DISP_OFF = 8'h3E;
    localparam logic [7:0] INSTR_DISP_ON  = 8'h3F;
    localparam logic [7:0] INSTR_COL      = 8'h40;
    localparam logic [7:0] INSTR_COL_MASK = 8'hC0;
    localparam logic [7:0] INSTR_PAGE     = 8'hB8;
    localparam logic [7:0] INSTR_PAGE_MSK = 8'hF8;
    localparam logic [7:0] INSTR_LINE     = 8'hC0;
    localparam logic [7:0] INSTR_LINE_MSK = 8'hC0;

    // Status bytes: busy and reset always clear, bit 5 flags display off
    localparam logic [7:0] STATUS_ON  = 8'h00;
    localparam logic [7:0] STATUS_OFF = 8'h20;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DISP,
        CMD_COL,
        CMD_PAGE,
        CMD_LINE
    } dglcd_cmd_t;

    // Per-half control from the sequencer
    typedef struct packed {
        logic       instr_we;
        logic       col_adv;
        logic [7:0] instr;
    } dglcd_half_ctl_t;

    // Per-half status toward the sequencer
    typedef struct packed {
        logic              disp_on;
        logic [ADDR_W-1:0] addr;
    } dglcd_half_st_t;

    function automatic dglcd_cmd_t decode_instr(logic [7:0] b);
        dglcd_cmd_t c;
        c = CMD_NONE;
        if (b == INSTR_DISP_OFF || b == INSTR_DISP_ON)
            c = CMD_DISP;
        else if ((b & INSTR_COL_MASK) == INSTR_COL)
            c = CMD_COL;
        else if ((b & INSTR_PAGE_MSK) == INSTR_PAGE)
            c = CMD_PAGE;
        else if ((b & INSTR_LINE_MSK) == INSTR_LINE)
            c = CMD_LINE;
        return c;
    endfunction

    // Fold a 6-bit column argument into the half's column range
    function automatic logic [COL_W-1:0] col_wrap(logic [5:0] v);
        logic [6:0] t;
        t = {1'b0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 7'(COLUMNS_PER_HALF))
                t = t - 7'(COLUMNS_PER_HALF);
        end
        return COL_W'(t);
    endfunction

    // Fold a 3-bit page argument into the page range
    function automatic logic [PAGE_W-1:0] page_wrap(logic [2:0] v);
        logic [3:0] t;
        t = {1'b0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 4'(PAGE_COUNT))
                t = t - 4'(PAGE_COUNT);
        end
        return PAGE_W'(t);
    endfunction

    function automatic logic [COL_W-1:0] col_inc(logic [COL_W-1:0] c);
        logic [COL_W:0] n;
        n = {1'b0, c} + (COL_W+1)'(1);
        return (n >= (COL_W+1)'(COLUMNS_PER_HALF)) ? '0 : COL_W'(n);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [PAGE_W-1:0] p,
                                                   logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(p) * ADDR_W'(COLUMNS_PER_HALF)) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== design/dglcd_in_if.sv =====
// Bus access channel: valid/ready handshake carrying one access item.
// Depends on nothing.
`default_nettype none

interface dglcd_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic       reg_select;
    logic       select_left;
    logic       select_right;
    logic [7:0] bus_data;

    modport source (output valid, op, reg_select, select_left, select_right, bus_data,
                    input ready);
    modport sink   (input valid, op, reg_select, select_left, select_right, bus_data,
                    output ready);
endinterface

`default_nettype wire

// ===== design/dglcd_out_if.sv =====
// Read result channel: valid/ready handshake carrying one read byte item.
// Depends on nothing.
`default_nettype none

interface dglcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ===== design/dual_half_graphic_lcd_controller_top.sv =====
// Bus side of a two-half graphic LCD controller: access sequencer, display RAMs, result register.
// Depends on dglcd_pkg, dglcd_in_if, dglcd_out_if, dglcd_ram and dglcd_half.
//
// Usage:
//   in_ch carries one bus access per item: op (0 write, 1 read), reg_select
//   (0 instruction/status, 1 display data), the two chip selects and bus_data.
//   out_ch carries one read_data item for each read with at least one half
//   selected; writes, instructions and unselected accesses give no item.
//   Each half keeps its display bytes in its own synchronous RAM with a
//   registered read; a data access reads or writes the addressed byte and
//   advances that half's column in the same cycle.
//   A read's item passes through the pending stage (RAM read) and then the
//   single result register before it is valid on out_ch.
//   Throughput: one item per cycle while out_ch takes results.
//   Stall: a read waits in the pending stage while out_ch is stalled with a
//   result; in_ch then deasserts ready until the result register frees up.
//   Writes and instructions flow on meanwhile only when no read is waiting.
//   Reset: page, column and display-on of both halves clear (display off);
//   no item is pending. Display RAM contents stay undefined until written.
`default_nettype none

module dual_half_graphic_lcd_controller_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dglcd_in_if.sink     in_ch,
    dglcd_out_if.source  out_ch
);

    dglcd_pkg::dglcd_half_ctl_t ctl_l, ctl_r;
    dglcd_pkg::dglcd_half_st_t  st_l, st_r;

    logic       acc, wr, rd, is_data, sel_l, sel_r;
    logic       we_l, we_r, re_l, re_r, rd_any;
    logic [7:0] rdata_l, rdata_r, status_byte;
    logic       out_free;

    logic       pend_reg;
    logic       pend_src_reg;
    logic       pend_data_reg;
    logic [7:0] pend_status_reg;
    logic       out_valid_reg;
    logic [7:0] read_data_reg;

    // Decode the accepted access
    assign acc     = in_ch.valid && in_ch.ready;
    assign wr      = acc && (in_ch.op == dglcd_pkg::OP_WRITE);
    assign rd      = acc && (in_ch.op == dglcd_pkg::OP_READ);
    assign is_data = (in_ch.reg_select == dglcd_pkg::RS_DATA);
    assign sel_l   = in_ch.select_left;
    assign sel_r   = in_ch.select_right;
    assign rd_any  = rd && (sel_l || sel_r);

    // Per-half control: instructions on writes, column advance on data accesses
    assign ctl_l.instr_we = wr && !is_data && sel_l;
    assign ctl_l.col_adv  = acc && is_data && sel_l;
    assign ctl_l.instr    = in_ch.bus_data;
    assign ctl_r.instr_we = wr && !is_data && sel_r;
    assign ctl_r.col_adv  = acc && is_data && sel_r;
    assign ctl_r.instr    = in_ch.bus_data;

    // RAM strobes; reads come from the left half when both are selected
    assign we_l = wr && is_data && sel_l;
    assign we_r = wr && is_data && sel_r;
    assign re_l = rd && is_data && sel_l;
    assign re_r = rd && is_data && !sel_l && sel_r;

    assign status_byte = (sel_l ? st_l.disp_on : st_r.disp_on) ?
                         dglcd_pkg::STATUS_ON : dglcd_pkg::STATUS_OFF;

    dglcd_half u_half_l (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_l),
        .st    (st_l)
    );

    dglcd_half u_half_r (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_r),
        .st    (st_r)
    );

    dglcd_ram #(
        .DEPTH (dglcd_pkg::HALF_DEPTH),
        .WIDTH (8)
    ) u_ram_l (
        .clk   (clk),
        .we    (we_l),
        .re    (re_l),
        .addr  (st_l.addr),
        .wdata (in_ch.bus_data),
        .rdata (rdata_l)
    );

    dglcd_ram #(
        .DEPTH (dglcd_pkg::HALF_DEPTH),
        .WIDTH (8)
    ) u_ram_r (
        .clk   (clk),
        .we    (we_r),
        .re    (re_r),
        .addr  (st_r.addr),
        .wdata (in_ch.bus_data),
        .rdata (rdata_r)
    );

    // Take a new item unless a read waits behind a stalled result
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !pend_reg || out_free;

    // Pending read and result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pend_reg && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (rd_any)
                pend_reg <= 1'b1;
            else if (out_free)
                pend_reg <= 1'b0;
        end
    end

    // Capture the read source on accept; move the byte out when the slot frees
    always_ff @(posedge clk)
    begin
        if (rd_any)
        begin
            pend_src_reg    <= !sel_l;
            pend_data_reg   <= is_data;
            pend_status_reg <= status_byte;
        end
        if (pend_reg && out_free)
        begin
            if (pend_data_reg)
                read_data_reg <= pend_src_reg ? rdata_r : rdata_l;
            else
                read_data_reg <= pend_status_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.read_data = read_data_reg;

    // A read that is accepted is pending in the next cycle
    a_read_pends: assert property (@(posedge clk) disable iff (!rst_n)
        rd_any |=> pend_reg)
        else $error("accepted read not pending");

    // A pending read with a free result slot reaches the output
    a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && out_free |=> out_valid_reg)
        else $error("pending read not delivered");

    // Never read both RAMs for one access
    a_one_ram_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(re_l && re_r))
        else $error("both display RAMs read");

    // A pending read stalled behind the output keeps its slot and blocks input
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !out_free |=> pend_reg && out_valid_reg)
        else $error("pending read lost under stall");

endmodule

`default_nettype wire

// ===== design/dglcd_ram.sv =====
// Generic single-port synchronous RAM, registered read.
// Depends on nothing.
`default_nettype none

module dglcd_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                     wdata,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
    end

    // Registered read; hold the last word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/dglcd_half.sv =====
// Address and display-on registers of one display half, with instruction decode.
// Depends on dglcd_pkg.
`default_nettype none

module dglcd_half (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dglcd_pkg::dglcd_half_ctl_t ctl,
    output dglcd_pkg::dglcd_half_st_t      st
);

    logic [dglcd_pkg::PAGE_W-1:0] page_reg, page_next;
    logic [dglcd_pkg::COL_W-1:0]  col_reg, col_next;
    logic                         disp_on_reg, disp_on_next;
    dglcd_pkg::dglcd_cmd_t        cmd;

    assign cmd = dglcd_pkg::decode_instr(ctl.instr);

    // Apply an instruction or advance the column after a data access.
    // The start line only moves the scan origin, so its command changes nothing here.
    always_comb
    begin
        page_next    = page_reg;
        col_next     = col_reg;
        disp_on_next = disp_on_reg;
        if (ctl.col_adv)
            col_next = dglcd_pkg::col_inc(col_reg);
        else if (ctl.instr_we)
        begin
            unique case (cmd)
                dglcd_pkg::CMD_DISP: disp_on_next = ctl.instr[0];
                dglcd_pkg::CMD_COL:  col_next = dglcd_pkg::col_wrap(ctl.instr[5:0]);
                dglcd_pkg::CMD_PAGE: page_next = dglcd_pkg::page_wrap(ctl.instr[2:0]);
                dglcd_pkg::CMD_LINE: ;
                dglcd_pkg::CMD_NONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg    <= '0;
            col_reg     <= '0;
            disp_on_reg <= 1'b0;
        end
        else
        begin
            page_reg    <= page_next;
            col_reg     <= col_next;
            disp_on_reg <= disp_on_next;
        end
    end

    assign st.disp_on = disp_on_reg;
    assign st.addr    = dglcd_pkg::cell_addr(page_reg, col_reg);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for dual_half_graphic_lcd_controller_top: directed and random bus accesses
// checked against a shadow of both display halves. Depends on dglcd_pkg,
// dglcd_in_if, dglcd_out_if and the controller RTL.
`timescale 1ns / 100ps

module tb;
    import dglcd_pkg::*;

    typedef struct packed {
        logic       op;
        logic       reg_select;
        logic       sel_l;
        logic       sel_r;
        logic [7:0] data;
    } lcd_access_t;

    // Shadow of both halves; predicts the byte of every read and holds it until it arrives
    class lcd_shadow;
        bit [7:0]        mem [2][HALF_DEPTH];
        bit              written [2][HALF_DEPTH];
        bit [PAGE_W-1:0] page [2];
        bit [COL_W-1:0]  col [2];
        bit [5:0]        line [2];
        bit              disp_on [2];
        bit [7:0]        read_bytes_due [$];
        int              mismatches = 0;

        function int cell_at(int h);
            return int'(page[h]) * COLUMNS_PER_HALF + int'(col[h]);
        endfunction

        function void next_column(int h);
            if (int'(col[h]) + 1 >= COLUMNS_PER_HALF)
                col[h] = '0;
            else
                col[h] = col[h] + 1'b1;
        endfunction

        function void run_instr(int h, bit [7:0] b);
            if (b == INSTR_DISP_OFF || b == INSTR_DISP_ON)
                disp_on[h] = b[0];
            else if ((b & INSTR_COL_MASK) == INSTR_COL)
                col[h] = COL_W'(int'(b[5:0]) % COLUMNS_PER_HALF);
            else if ((b & INSTR_PAGE_MSK) == INSTR_PAGE)
                page[h] = PAGE_W'(int'(b[2:0]) % PAGE_COUNT);
            else if ((b & INSTR_LINE_MSK) == INSTR_LINE)
                line[h] = b[5:0];
        endfunction

        // A data read must only hit a byte written since reset
        function bit readable(lcd_access_t a);
            int src;
            if (a.op != OP_READ || a.reg_select != RS_DATA || !(a.sel_l || a.sel_r))
                return 1'b1;
            src = a.sel_l ? 0 : 1;
            return written[src][cell_at(src)];
        endfunction

        // Apply one accepted access and queue the byte it returns, if any
        function void note_access(lcd_access_t a);
            bit sel [2];
            int src;
            sel[0] = a.sel_l;
            sel[1] = a.sel_r;
            if (!sel[0] && !sel[1])
                return;
            if (a.op == OP_WRITE)
            begin
                for (int h = 0; h < 2; h++)
                begin
                    if (!sel[h])
                        continue;
                    if (a.reg_select == RS_DATA)
                    begin
                        mem[h][cell_at(h)] = a.data;
                        written[h][cell_at(h)] = 1'b1;
                        next_column(h);
                    end
                    else
                        run_instr(h, a.data);
                end
                return;
            end
            src = sel[0] ? 0 : 1;
            if (a.reg_select == RS_DATA)
            begin
                read_bytes_due.push_back(mem[src][cell_at(src)]);
                for (int h = 0; h < 2; h++)
                    if (sel[h])
                        next_column(h);
            end
            else
                read_bytes_due.push_back(disp_on[src] ? STATUS_ON : STATUS_OFF);
        endfunction

        function void check_read(bit [7:0] got);
            bit [7:0] want;
            if (read_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected read_data %02h, nothing expected", $time, got);
                mismatches++;
                return;
            end
            want = read_bytes_due.pop_front();
            if (got !== want)
            begin
                $display("%0t: read_data mismatch, expected %02h, actual %02h",
                         $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dglcd_in_if  in_ch ();
    dglcd_out_if out_ch ();

    dual_half_graphic_lcd_controller_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lcd_shadow shadow = new;
    bit        no_idle = 1'b0;
    bit        long_hold_req = 1'b0;
    int        items_sent = 0;
    int        hold_cycles = 0;

    // Last written burst, reused so that read bursts land on written bytes
    bit [1:0]  last_sel = 2'b00;
    int        last_pg = 0;
    int        last_col = 0;
    int        last_len = 0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(int quiet_pct);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < quiet_pct)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic lcd_access_t acc(logic op, logic rs, logic sl, logic sr,
                                        logic [7:0] d);
        lcd_access_t a;
        a.op = op;
        a.reg_select = rs;
        a.sel_l = sl;
        a.sel_r = sr;
        a.data = d;
        return a;
    endfunction

    // Chip selects as {left, right}
    function automatic bit [1:0] rand_sel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 2'b10;
        if (r < 80)
            return 2'b01;
        if (r < 97)
            return 2'b11;
        return 2'b00;
    endfunction

    // Receiver: check each accepted item, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            shadow.check_read(out_ch.read_data);
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_cycles = 250;
        end
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            hold_cycles = pick_gap(65);
        end
    end

    // Offer one access until taken, record it, then sometimes idle for a while
    task automatic send_access(input lcd_access_t a);
        lcd_access_t b;
        int gap;
        b = a;
        if (!shadow.readable(b))
            b.op = OP_WRITE;
        in_ch.valid        <= 1'b1;
        in_ch.op           <= b.op;
        in_ch.reg_select   <= b.reg_select;
        in_ch.select_left  <= b.sel_l;
        in_ch.select_right <= b.sel_r;
        in_ch.bus_data     <= b.data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        shadow.note_access(b);
        if (b.sel_l || b.sel_r)
            items_sent++;
        gap = pick_gap(60);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the input until every read item has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (shadow.read_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_cursor(bit [1:0] sel, int pg, int c);
        send_access(acc(OP_WRITE, RS_INSTR, sel[1], sel[0], INSTR_PAGE | 8'(pg)));
        send_access(acc(OP_WRITE, RS_INSTR, sel[1], sel[0], INSTR_COL | 8'(c)));
    endtask

    task automatic directed_accesses();
        // Status of both halves after reset, then display on for the left one
        send_access(acc(OP_READ, RS_INSTR, 1'b1, 1'b0, 8'h00));
        send_access(acc(OP_READ, RS_INSTR, 1'b0, 1'b1, 8'hFF));
        send_access(acc(OP_WRITE, RS_INSTR, 1'b1, 1'b0, INSTR_DISP_ON));
        send_access(acc(OP_READ, RS_INSTR, 1'b1, 1'b1, 8'h00));
        send_access(acc(OP_READ, RS_INSTR, 1'b0, 1'b1, 8'h00));
        // Last page, last column: write both halves across the column wrap
        set_cursor(2'b11, PAGE_COUNT - 1, COLUMNS_PER_HALF - 1);
        send_access(acc(OP_WRITE, RS_DATA, 1'b1, 1'b1, 8'hFF));
        send_access(acc(OP_WRITE, RS_DATA, 1'b1, 1'b1, 8'h00));
        send_access(acc(OP_WRITE, RS_INSTR, 1'b1, 1'b1, INSTR_COL | 8'h3F));
        // Read with both selected returns left and advances both columns
        send_access(acc(OP_READ, RS_DATA, 1'b1, 1'b1, 8'h00));
        send_access(acc(OP_READ, RS_DATA, 1'b0, 1'b1, 8'hFF));
        send_access(acc(OP_READ, RS_DATA, 1'b1, 1'b0, 8'h00));
        // Start line extremes and ignored bytes
        send_access(acc(OP_WRITE, RS_INSTR, 1'b1, 1'b1, INSTR_LINE));
        send_access(acc(OP_WRITE, RS_INSTR, 1'b1, 1'b1, 8'hFF));
        send_access(acc(OP_WRITE, RS_INSTR, 1'b1, 1'b1, 8'h00));
        send_access(acc(OP_WRITE, RS_INSTR, 1'b1, 1'b1, 8'h3D));
        send_access(acc(OP_WRITE, RS_INSTR, 1'b1, 1'b1, 8'h80));
        // No half selected: no effect, no item
        send_access(acc(OP_WRITE, RS_DATA, 1'b0, 1'b0, 8'hAA));
        send_access(acc(OP_READ, RS_DATA, 1'b0, 1'b0, 8'h55));
        send_access(acc(OP_READ, RS_INSTR, 1'b0, 1'b0, 8'h00));
        // Display off left, on right
        send_access(acc(OP_WRITE, RS_INSTR, 1'b1, 1'b0, INSTR_DISP_OFF));
        send_access(acc(OP_WRITE, RS_INSTR, 1'b0, 1'b1, INSTR_DISP_ON));
        send_access(acc(OP_READ, RS_INSTR, 1'b1, 1'b1, 8'h00));
        send_access(acc(OP_READ, RS_INSTR, 1'b0, 1'b1, 8'h00));
    endtask

    // Random traffic: mostly cursor-then-burst sequences, the rest noise
    task automatic random_accesses(int count, bit read_heavy);
        int goal;
        int r;
        int len;
        int pg;
        int c;
        bit [1:0] sel;
        bit [7:0] b;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            r = read_heavy ? $urandom_range(35, 64) : $urandom_range(0, 99);
            sel = rand_sel();
            if (sel == 2'b00)
                sel = 2'b10;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 70)
                                              : $urandom_range(1, 16);
            if (r < 35)
            begin
                pg = $urandom_range(0, PAGE_COUNT - 1);
                c = $urandom_range(0, COLUMNS_PER_HALF - 1);
                set_cursor(sel, pg, c);
                for (int i = 0; i < len; i++)
                    send_access(acc(OP_WRITE, RS_DATA, sel[1], sel[0], 8'($urandom)));
                last_sel = sel;
                last_pg = pg;
                last_col = c;
                last_len = len;
            end
            else if (r < 65)
            begin
                if (last_len > 0 && $urandom_range(0, 9) < 7)
                begin
                    if (last_sel == 2'b11 && $urandom_range(0, 1) == 1)
                        sel = $urandom_range(0, 1) ? 2'b10 : 2'b01;
                    else
                        sel = last_sel;
                    pg = last_pg;
                    c = last_col;
                    len = last_len;
                end
                else
                begin
                    pg = $urandom_range(0, PAGE_COUNT - 1);
                    c = $urandom_range(0, COLUMNS_PER_HALF - 1);
                end
                set_cursor(sel, pg, c);
                for (int i = 0; i < len; i++)
                    send_access(acc(OP_READ, RS_DATA, sel[1], sel[0], 8'($urandom)));
            end
            else if (r < 80)
            begin
                if ($urandom_range(0, 3) == 0)
                    b = $urandom_range(0, 1) ? INSTR_DISP_ON : INSTR_DISP_OFF;
                else
                    b = 8'($urandom);
                sel = rand_sel();
                send_access(acc(OP_WRITE, RS_INSTR, sel[1], sel[0], b));
            end
            else if (r < 92)
            begin
                sel = rand_sel();
                send_access(acc(OP_READ, RS_INSTR, sel[1], sel[0], 8'($urandom)));
            end
            else
                send_access(acc(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                                8'($urandom)));
        end
    endtask

    initial
    begin
        in_ch.valid        <= 1'b0;
        in_ch.op           <= OP_WRITE;
        in_ch.reg_select   <= RS_INSTR;
        in_ch.select_left  <= 1'b0;
        in_ch.select_right <= 1'b0;
        in_ch.bus_data     <= 8'h00;
        rst_n              <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_accesses();
        drain();

        random_accesses(300, 1'b0);

        // Run back to back on both sides
        no_idle = 1'b1;
        random_accesses(150, 1'b0);
        no_idle = 1'b0;

        // Stall the receiver for a long stretch while reads keep coming
        long_hold_req = 1'b1;
        random_accesses(100, 1'b1);
        drain();

        random_accesses(350, 1'b0);
        drain();
        repeat (8) @(posedge clk);

        if (shadow.read_bytes_due.size() != 0)
        begin
            $display("%0t: %0d read items never arrived", $time,
                     shadow.read_bytes_due.size());
            shadow.mismatches++;
        end
        if (shadow.mismatches == 0)
            $display("dual_half_graphic_lcd_controller_top regression: pass");
        else
            $display("dual_half_graphic_lcd_controller_top regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("dual_half_graphic_lcd_controller_top regression: fail");
        $finish;
    end

endmodule
